### src/psa_pkg.sv
// Shared types and constants of the pixel saturation adjust unit.
`timescale 1ns / 1ps
package psa_pkg;

    // Configuration register indexes.
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_INC  = 1'b1;

    // Register widths and reset values.
    localparam int GAIN_W = 10;
    localparam int INC_W  = 11;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd666;
    localparam logic [INC_W-1:0]  INC_RESET  = 11'd922;

    // Fixed-point constants: full scale 510 in Q.8 and one in Q.10.
    localparam logic signed [20:0] FULL_Q8 = 21'sd130560;
    localparam logic signed [12:0] ONE_Q10 = 13'sd1024;

    // Datapath widths.
    localparam int T_W   = 18;  // scaled channel, Q.8
    localparam int SUM_W = 20;  // max + min
    localparam int OP_W  = 21;  // signed multiplier operand
    localparam int P_W   = 42;  // signed product
    localparam int NUM_W = 48;  // rounding numerator
    localparam int DEN_W = 27;  // denominator
    localparam int DVS_W = 28;  // doubled denominator
    localparam int REM_W = 36;  // division remainder

    // Input and output words.
    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } t_pix_out;

    // Front end to operand mixer.
    typedef struct packed {
        logic [SUM_W-1:0]        sum;
        logic [T_W-1:0]          spread;
        logic [OP_W-1:0]         dms;
        logic                    inf;
        logic                    use_s;
        logic [2:0][T_W:0]       tt;
        logic [2:0][OP_W-1:0]    d;
    } t_front;

    // Operand mixer to divider.
    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [DVS_W-1:0]      dvs;
    } t_divin;

endpackage

### src/pixel_saturation_adjust_unit.sv
// Top level of the pixel saturation adjust unit.
//
//  Channel   Signals                          Word
//  input     i_valid / o_ready / i_pix        blue, green, red in
//  output    o_valid / i_ready / o_pix        blue, green, red out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data gain (0), increment (1)
//
// One word enters per clock while o_ready is high, through 3 front, 3 mixer and 9 divider stages.
// Most stages belong to the restoring divider: a clamp stage, then one quotient bit per stage.
// Every stage has its own valid bit and ready, so bubbles collapse on a stall.
// Reset is synchronous and active low; it clears valid bits and loads
// the register reset values.
`timescale 1ns / 1ps
module pixel_saturation_adjust_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  psa_pkg::t_pix_in         i_pix,
    output logic                     o_valid,
    input  logic                     i_ready,
    output psa_pkg::t_pix_out        o_pix,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [psa_pkg::INC_W-1:0] i_cfg_data
);
    logic [psa_pkg::GAIN_W-1:0] r_gain;
    logic signed [psa_pkg::INC_W-1:0] r_inc;
    logic w_f_valid, w_f_ready, w_m_valid, w_m_ready;
    psa_pkg::t_front w_f_data;
    psa_pkg::t_divin w_m_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= psa_pkg::GAIN_RESET;
            r_inc  <= psa_pkg::INC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psa_pkg::REG_GAIN: r_gain <= i_cfg_data[psa_pkg::GAIN_W-1:0];
                psa_pkg::REG_INC:  r_inc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    psa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .i_gain  (r_gain),
        .i_inc   (r_inc),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_data  (w_f_data)
    );

    psa_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_data),
        .i_inc   (r_inc),
        .o_valid (w_m_valid),
        .i_ready (w_m_ready),
        .o_data  (w_m_data)
    );

    psa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_valid),
        .o_ready (w_m_ready),
        .i_data  (w_m_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (o_pix)
    );

    // The input side can only stall when the whole pipeline is full.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && w_m_valid && w_f_valid))
        else $error("input stalled with an empty stage");

    // Nothing leaves the pipeline right after reset.
    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output word valid after reset");

    // A gain write lands in the gain register.
    a_gain_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == psa_pkg::REG_GAIN)
            |=> r_gain == $past(i_cfg_data[psa_pkg::GAIN_W-1:0]))
        else $error("gain register not updated");

endmodule

### src/psa_front.sv
// Front end: channel gain, min/max, saturation compare (three stages).
`timescale 1ns / 1ps
module psa_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  psa_pkg::t_pix_in             i_pix,
    input  logic [psa_pkg::GAIN_W-1:0]   i_gain,
    input  logic signed [psa_pkg::INC_W-1:0] i_inc,
    output logic                         o_valid,
    input  logic                         i_ready,
    output psa_pkg::t_front              o_data
);
    logic [2:0] r_v;
    logic [3:0] w_rdy;
    logic [2:0][7:0] w_ch;
    logic [2:0][psa_pkg::T_W-1:0] r_t;

    logic [psa_pkg::T_W-1:0] w_mx, w_mn;
    logic [psa_pkg::SUM_W-1:0] w_sum;
    logic signed [20:0] w_d2, w_sum_s;
    logic [psa_pkg::SUM_W-1:0] w_dmin;
    logic [psa_pkg::SUM_W-1:0] r_sum;
    logic [psa_pkg::T_W-1:0] r_spread;
    logic [psa_pkg::SUM_W-1:0] r_dmin;
    logic r_inf;
    logic [2:0][psa_pkg::T_W:0] r_tt;
    logic [2:0][psa_pkg::OP_W-1:0] r_d;

    logic signed [12:0] w_om_full;
    logic [30:0] w_rhs, w_lhs;
    psa_pkg::t_front r_out;

    // Per-stage ready chain lets bubbles collapse.
    assign w_rdy[3] = i_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[2];
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    assign w_ch[0] = i_pix.blue_in;
    assign w_ch[1] = i_pix.green_in;
    assign w_ch[2] = i_pix.red_in;

    // Stage 0: scale each channel by the gain.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int c = 0; c < 3; c++) begin
                r_t[c] <= psa_pkg::T_W'(w_ch[c]) * psa_pkg::T_W'(i_gain);
            end
        end
    end

    // Stage 1: extremes, sum, spread, the smaller denominator, the zero flag and channel differences.
    always_comb begin
        w_mx = r_t[0];
        w_mn = r_t[0];
        for (int c = 1; c < 3; c++) begin
            if (r_t[c] > w_mx) w_mx = r_t[c];
            if (r_t[c] < w_mn) w_mn = r_t[c];
        end
        w_sum   = psa_pkg::SUM_W'(w_mx) + psa_pkg::SUM_W'(w_mn);
        w_sum_s = $signed({1'b0, w_sum});
        w_d2    = psa_pkg::FULL_Q8 - w_sum_s;
        w_dmin  = (w_d2 > 0 && w_d2 < w_sum_s) ? w_d2[psa_pkg::SUM_W-1:0] : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_sum    <= w_sum;
            r_spread <= w_mx - w_mn;
            r_dmin   <= w_dmin;
            r_inf    <= (w_sum == '0) || (w_d2 == '0);
            for (int c = 0; c < 3; c++) begin
                r_tt[c] <= {r_t[c], 1'b0};
                r_d[c]  <= psa_pkg::OP_W'($signed({2'b00, r_t[c], 1'b0})
                           - $signed({1'b0, w_sum}));
            end
        end
    end

    // Stage 2: pick the saturation term or one minus the increment.
    always_comb begin
        w_om_full = psa_pkg::ONE_Q10 - 13'(i_inc);
        w_rhs = 31'(w_om_full[10:0]) * 31'(r_dmin);
        w_lhs = 31'({r_spread, 10'd0});
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_out.sum    <= r_sum;
            r_out.spread <= r_spread;
            r_out.dms    <= psa_pkg::OP_W'($signed({1'b0, r_dmin})
                            - $signed({3'b000, r_spread}));
            r_out.inf    <= r_inf;
            r_out.use_s  <= w_lhs >= w_rhs;
            r_out.tt     <= r_tt;
            r_out.d      <= r_d;
        end
    end

endmodule

### src/psa_mix.sv
// Operand mixer: branch select, products and rounding numerator (three stages).
`timescale 1ns / 1ps
module psa_mix (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  psa_pkg::t_front                  i_data,
    input  logic signed [psa_pkg::INC_W-1:0] i_inc,
    output logic                             o_valid,
    input  logic                             i_ready,
    output psa_pkg::t_divin                  o_data
);
    logic [2:0] r_v;
    logic [3:0] w_rdy;
    logic w_inc_le0;
    logic signed [psa_pkg::OP_W-1:0] w_one, w_om, w_op, w_incx, w_sum, w_spr;
    logic signed [psa_pkg::OP_W-1:0] r_a1 [3], r_b1 [3], r_a2 [3], r_b2 [3];
    logic [psa_pkg::DEN_W-1:0] r_den0, r_den1, w_den;
    logic signed [psa_pkg::P_W-1:0] r_p1 [3], r_p2 [3];
    logic signed [psa_pkg::NUM_W-1:0] w_acc [3];
    psa_pkg::t_divin r_out;

    assign w_rdy[3] = i_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[2];
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    // Common operand values.
    always_comb begin
        w_inc_le0 = i_inc[psa_pkg::INC_W-1] || (i_inc == '0);
        w_one  = psa_pkg::OP_W'(psa_pkg::ONE_Q10);
        w_incx = psa_pkg::OP_W'(i_inc);
        w_om   = w_one - w_incx;
        w_op   = w_one + w_incx;
        w_sum  = $signed({1'b0, i_data.sum});
        w_spr  = $signed({3'b000, i_data.spread});
        if (w_inc_le0) begin
            w_den = psa_pkg::DEN_W'(1) << 19;
        end else if (i_data.inf) begin
            w_den = psa_pkg::DEN_W'(512);
        end else if (i_data.use_s) begin
            w_den = {i_data.spread, 9'd0};
        end else begin
            w_den = psa_pkg::DEN_W'({w_om[10:0], 9'd0});
        end
    end

    // Stage 0: select the two products of each channel.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_den0 <= w_den;
            for (int c = 0; c < 3; c++) begin
                if (w_inc_le0) begin
                    r_a1[c] <= w_sum;
                    r_b1[c] <= w_one;
                    r_a2[c] <= $signed(i_data.d[c]);
                    r_b2[c] <= w_op;
                end else if (i_data.inf) begin
                    r_a1[c] <= w_sum;
                    r_b1[c] <= psa_pkg::OP_W'(1);
                    r_a2[c] <= '0;
                    r_b2[c] <= '0;
                end else if (i_data.use_s) begin
                    r_a1[c] <= $signed({2'b00, i_data.tt[c]});
                    r_b1[c] <= w_spr;
                    r_a2[c] <= $signed(i_data.d[c]);
                    r_b2[c] <= $signed(i_data.dms);
                end else begin
                    r_a1[c] <= $signed({2'b00, i_data.tt[c]});
                    r_b1[c] <= w_om;
                    r_a2[c] <= $signed(i_data.d[c]);
                    r_b2[c] <= w_incx;
                end
            end
        end
    end

    // Stage 1: the multipliers.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_den1 <= r_den0;
            for (int c = 0; c < 3; c++) begin
                r_p1[c] <= r_a1[c] * r_b1[c];
                r_p2[c] <= r_a2[c] * r_b2[c];
            end
        end
    end

    // Stage 2: numerator 2*num + den and divisor 2*den for round-half-up.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_acc[c] = ((psa_pkg::NUM_W'(r_p1[c]) + psa_pkg::NUM_W'(r_p2[c])) <<< 1)
                       + $signed({21'd0, r_den1});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_out.dvs <= {r_den1, 1'b0};
            for (int c = 0; c < 3; c++) begin
                r_out.num[c] <= w_acc[c];
            end
        end
    end

endmodule

### src/psa_div.sv
// Pipelined restoring divider with clamp to 0..255: a clamp stage, then one quotient bit a stage.
`timescale 1ns / 1ps
module psa_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  psa_pkg::t_divin i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output psa_pkg::t_pix_out o_pix
);
    localparam int NS = 9;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;
    logic [psa_pkg::REM_W-1:0] r_rem [NS][3];
    logic [7:0]                r_q   [NS][3];
    logic                      r_hi  [NS][3];
    logic [psa_pkg::DVS_W-1:0] r_dvs [NS];
    logic [7:0] w_res [3];

    assign w_rdy[NS] = i_ready;
    assign o_ready   = w_rdy[0];
    assign o_valid   = r_v[NS-1];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_rdy
            assign w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage 0: negative clamps to zero, a quotient past 255 clamps high.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_dvs[0] <= i_data.dvs;
            for (int c = 0; c < 3; c++) begin
                logic neg, big;
                neg = i_data.num[c][psa_pkg::NUM_W-1];
                big = !neg && (i_data.num[c] >= {12'd0, i_data.dvs, 8'd0});
                r_hi[0][c]  <= big;
                r_q[0][c]   <= '0;
                r_rem[0][c] <= (neg || big) ? '0 : i_data.num[c][psa_pkg::REM_W-1:0];
            end
        end
    end

    // Stages 1..8: one trial subtraction each, most significant bit first.
    generate
        for (s = 1; s < NS; s++) begin : g_step
            localparam int B = NS - 1 - s;
            always_ff @(posedge i_clk) begin
                if (w_rdy[s]) begin
                    r_dvs[s] <= r_dvs[s-1];
                    for (int c = 0; c < 3; c++) begin
                        logic [psa_pkg::REM_W-1:0] sh;
                        sh = psa_pkg::REM_W'(r_dvs[s-1]) << B;
                        r_hi[s][c] <= r_hi[s-1][c];
                        if (r_rem[s-1][c] >= sh) begin
                            r_rem[s][c] <= r_rem[s-1][c] - sh;
                            r_q[s][c]   <= r_q[s-1][c] | (8'd1 << B);
                        end else begin
                            r_rem[s][c] <= r_rem[s-1][c];
                            r_q[s][c]   <= r_q[s-1][c];
                        end
                    end
                end
            end
        end
    endgenerate

    // Final saturation.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_res[c] = r_hi[NS-1][c] ? 8'd255 : r_q[NS-1][c];
        end
    end

    assign o_pix.blue_out  = w_res[0];
    assign o_pix.green_out = w_res[1];
    assign o_pix.red_out   = w_res[2];

endmodule
